// ===== rtl/core/srrw_pkg.sv =====
// Package for the selective-repeat receive window.
// Holds field widths, command and register codes, and the transaction structs.
`timescale 1ns / 1ps
package srrw_pkg;

    localparam int WINDOW_DEF   = 32;
    localparam int OFF_W        = 24;
    localparam int LEN_W        = 11;
    localparam int RETRY_W      = 16;
    localparam int TICK_W       = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int CNT_W        = OFF_W + 1;
    localparam int SEG_MAX      = 1024;
    localparam int SEG_RESET    = 1000;
    localparam int PROD_W       = CNT_W + 1 + LEN_W;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_BYTES   = 2'd0,
        REG_SEGMENT_BYTES = 2'd1,
        REG_RETRY_TICKS   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [OFF_W-1:0] seg_offset;
    } in_t;

    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] byte_start;
        logic [LEN_W-1:0] byte_len;
        logic             all_done;
        logic             last;
    } out_t;

endpackage

// ===== rtl/core/srrw_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the segment count and the offset-to-sequence conversion; uses srrw_pkg.
`timescale 1ns / 1ps
module srrw_div #(
    parameter int NUM_W = srrw_pkg::CNT_W,
    parameter int DEN_W = srrw_pkg::LEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = CW'(NUM_W);
            num_next   = num;
            den_next   = den;
            rem_next   = '0;
            quo_next   = '0;
        end else if (busy_reg) begin
            num_next   = {num_reg[NUM_W-2:0], 1'b0};
            rem_next   = fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_next   = {quo_reg[NUM_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/selective_repeat_receive_window.sv =====
// Top level of the selective-repeat receive window; uses srrw_pkg and srrw_div.
// Holds the window state, the sequencer, the shared multiplier and the output stage.
`timescale 1ns / 1ps
// Receiver window for a file pulled in fixed-size segments. Every start, tick
// or data item first runs the segment count through the bit-serial divider; a
// data item then runs a second division for its sequence number, followed by
// the window, multiply and sequence checks. The slot sequencer then visits one
// window slot per step and passes each result it produces through the multiply,
// trim and hand-off states. s_ready is high only while idle. The final result
// of an item is held until the scan ends so it carries last.
// Configuration writes are taken on any cycle.
module selective_repeat_receive_window #(
    parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  srrw_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output srrw_pkg::out_t                     m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import srrw_pkg::*;

    localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IW    = $clog2(WINDOW + 1);
    localparam int SEQ_W = CNT_W + 1;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b00000000001,
        ST_DIV_CNT = 11'b00000000010,
        ST_DIV_OFF = 11'b00000000100,
        ST_CHK_WIN = 11'b00000001000,
        ST_CHK_MUL = 11'b00000010000,
        ST_CHK_SEQ = 11'b00000100000,
        ST_SCAN    = 11'b00001000000,
        ST_MUL     = 11'b00010000000,
        ST_LEN     = 11'b00100000000,
        ST_PUSH    = 11'b01000000000,
        ST_FIN     = 11'b10000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [OFF_W-1:0]      total_reg;
    logic [LEN_W-1:0]      segb_reg;
    logic [RETRY_W-1:0]    retry_reg;

    logic [WINDOW-1:0]     acked_reg, acked_next;
    logic [OFF_W-1:0]      seqtab_reg [WINDOW];
    logic [OFF_W-1:0]      seqtab_next [WINDOW];
    logic [TICK_W-1:0]     sent_reg [WINDOW];
    logic [TICK_W-1:0]     sent_next [WINDOW];
    logic [OFF_W-1:0]      ne_reg, ne_next;
    logic [SW-1:0]         ne_slot_reg, ne_slot_next;
    logic [TICK_W-1:0]     now_reg, now_next;

    logic [1:0]            cmd_reg, cmd_next;
    logic [OFF_W-1:0]      off_reg, off_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      seq_reg, seq_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [SEQ_W-1:0]      cand_reg, cand_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    out_t                  res_reg, res_next;
    out_t                  pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    out_t                  out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic [LEN_W-1:0]      sb;
    logic                  div_start, div_done;
    logic [CNT_W-1:0]      div_num, div_quo;
    logic [SEQ_W-1:0]      mul_a;
    logic                  out_free;
    logic [SEQ_W-1:0]      scan_seq;
    logic [SEQ_W-1:0]      ne_ext;
    logic [SEQ_W-1:0]      dseq;
    logic [SW:0]           win_sum;
    logic [SW-1:0]         win_slot;
    logic [TICK_W-1:0]     elapsed;
    logic [PROD_W:0]       end_byte;
    logic                  s_fire;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW:0] t;
        t = {1'b0, s} + 1'b1;
        if (t >= (SW+1)'(WINDOW)) begin
            t = '0;
        end
        return t[SW-1:0];
    endfunction

    always_comb begin
        if (segb_reg == '0) begin
            sb = LEN_W'(1);
        end else if (segb_reg > LEN_W'(SEG_MAX)) begin
            sb = LEN_W'(SEG_MAX);
        end else begin
            sb = segb_reg;
        end
    end

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign div_start = (s_fire && s_data.cmd != CMD_NONE)
                    || (state_reg == ST_DIV_CNT && div_done && cmd_reg == CMD_DATA);
    assign div_num   = (state_reg == ST_IDLE)
                     ? CNT_W'({1'b0, total_reg} + {{(CNT_W-LEN_W){1'b0}}, sb} - 1'b1)
                     : CNT_W'(off_reg);

    srrw_div #(.NUM_W(CNT_W), .DEN_W(LEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (sb),
        .done    (div_done),
        .quo     (div_quo)
    );

    // shared multiplier: stored sequence during the data check, candidate otherwise
    assign mul_a     = (state_reg == ST_MUL) ? cand_reg : SEQ_W'(seqtab_reg[slot_reg]);
    assign prod_next = PROD_W'(mul_a) * PROD_W'(sb);

    assign ne_ext   = SEQ_W'(ne_reg);
    assign scan_seq = (cmd_reg == CMD_START) ? SEQ_W'(idx_reg) : ne_ext + SEQ_W'(idx_reg);
    assign dseq     = SEQ_W'(seq_reg) - ne_ext;
    assign win_sum  = {1'b0, ne_slot_reg} + (SW+1)'(dseq);
    assign win_slot = (win_sum >= (SW+1)'(WINDOW))
                    ? SW'(win_sum - (SW+1)'(WINDOW)) : win_sum[SW-1:0];
    assign elapsed  = now_reg - sent_reg[slot_reg];
    assign end_byte = {1'b0, prod_reg} + (PROD_W+1)'(sb);

    always_comb begin
        state_next      = state_reg;
        acked_next      = acked_reg;
        seqtab_next     = seqtab_reg;
        sent_next       = sent_reg;
        ne_next         = ne_reg;
        ne_slot_next    = ne_slot_reg;
        now_next        = now_reg;
        cmd_next        = cmd_reg;
        off_next        = off_reg;
        cnt_next        = cnt_reg;
        seq_next        = seq_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        cand_next       = cand_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.cmd != CMD_NONE) begin
                    cmd_next   = s_data.cmd;
                    off_next   = s_data.seg_offset;
                    state_next = ST_DIV_CNT;
                end
            end
            ST_DIV_CNT: begin
                if (div_done) begin
                    cnt_next  = div_quo;
                    idx_next  = '0;
                    slot_next = ne_slot_reg;
                    case (cmd_reg)
                        CMD_START: begin
                            for (int i = 0; i < WINDOW; i++) begin
                                seqtab_next[i] = OFF_W'(i);
                                sent_next[i]   = now_reg;
                            end
                            acked_next   = '0;
                            ne_next      = '0;
                            ne_slot_next = '0;
                            state_next   = ST_SCAN;
                        end
                        CMD_TICK: begin
                            now_next   = now_reg + 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_DIV_OFF;
                        end
                    endcase
                end
            end
            ST_DIV_OFF: begin
                if (div_done) begin
                    seq_next   = div_quo;
                    state_next = ST_CHK_WIN;
                end
            end
            ST_CHK_WIN: begin
                // drop stale, out-of-window and past-the-end segments
                if (SEQ_W'(seq_reg) < ne_ext
                        || SEQ_W'(seq_reg) >= ne_ext + SEQ_W'(WINDOW)
                        || seq_reg >= cnt_reg) begin
                    state_next = ST_FIN;
                end else begin
                    slot_next  = win_slot;
                    state_next = ST_CHK_MUL;
                end
            end
            ST_CHK_MUL: begin
                state_next = ST_CHK_SEQ;
            end
            ST_CHK_SEQ: begin
                if (acked_reg[slot_reg] || prod_reg != PROD_W'(off_reg)) begin
                    state_next = ST_FIN;
                end else begin
                    acked_next[slot_reg] = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                case (cmd_reg)
                    CMD_START: begin
                        if (idx_reg < IW'(WINDOW) && SEQ_W'(idx_reg) < SEQ_W'(cnt_reg)) begin
                            cand_next  = SEQ_W'(idx_reg);
                            res_next.kind = KIND_REQUEST;
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_MUL;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                    CMD_TICK: begin
                        if (idx_reg >= IW'(WINDOW) || scan_seq >= SEQ_W'(cnt_reg)) begin
                            state_next = ST_FIN;
                        end else begin
                            idx_next  = idx_reg + 1'b1;
                            slot_next = slot_inc(slot_reg);
                            if (!acked_reg[slot_reg]
                                    && elapsed >= TICK_W'(retry_reg)) begin
                                sent_next[slot_reg] = now_reg;
                                cand_next     = scan_seq;
                                res_next.kind = KIND_REQUEST;
                                state_next    = ST_MUL;
                            end
                        end
                    end
                    default: begin
                        if (CNT_W'(ne_reg) < cnt_reg && idx_reg < IW'(WINDOW)
                                && acked_reg[ne_slot_reg]) begin
                            acked_next[ne_slot_reg]  = 1'b0;
                            seqtab_next[ne_slot_reg] =
                                seqtab_reg[ne_slot_reg] + OFF_W'(WINDOW);
                            cand_next     = ne_ext;
                            res_next.kind = KIND_DELIVER;
                            ne_next       = ne_reg + 1'b1;
                            ne_slot_next  = slot_inc(ne_slot_reg);
                            idx_next      = idx_reg + 1'b1;
                            state_next    = ST_MUL;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                endcase
            end
            ST_MUL: begin
                state_next = ST_LEN;
            end
            ST_LEN: begin
                // trim the final segment to what remains of the file
                res_next.byte_start = prod_reg[OFF_W-1:0];
                res_next.byte_len   = sb;
                if (end_byte > (PROD_W+1)'(total_reg)) begin
                    res_next.byte_len = (prod_reg < PROD_W'(total_reg))
                        ? LEN_W'(total_reg - prod_reg[OFF_W-1:0]) : '0;
                end
                res_next.all_done = CNT_W'(ne_reg) >= cnt_reg;
                res_next.last     = 1'b0;
                state_next        = ST_PUSH;
            end
            ST_PUSH: begin
                if (!pend_valid_reg) begin
                    pend_next       = res_reg;
                    pend_valid_next = 1'b1;
                    state_next      = ST_SCAN;
                end else if (out_free) begin
                    out_next     = pend_reg;
                    m_valid_next = 1'b1;
                    pend_next    = res_reg;
                    state_next   = ST_SCAN;
                end
            end
            ST_FIN: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            segb_reg       <= LEN_W'(SEG_RESET);
            retry_reg      <= RETRY_W'(1);
            acked_reg      <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                seqtab_reg[i] <= OFF_W'(i);
                sent_reg[i]   <= '0;
            end
            ne_reg         <= '0;
            ne_slot_reg    <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acked_reg      <= acked_next;
            seqtab_reg     <= seqtab_next;
            sent_reg       <= sent_next;
            ne_reg         <= ne_next;
            ne_slot_reg    <= ne_slot_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TOTAL_BYTES:   total_reg <= cfg_data[OFF_W-1:0];
                    REG_SEGMENT_BYTES: segb_reg  <= cfg_data[LEN_W-1:0];
                    REG_RETRY_TICKS:   retry_reg <= cfg_data[RETRY_W-1:0];
                    default: ;
                endcase
            end
        end
        cmd_reg  <= cmd_next;
        off_reg  <= off_next;
        cnt_reg  <= cnt_next;
        seq_reg  <= seq_next;
        slot_reg <= slot_next;
        idx_reg  <= idx_next;
        cand_reg <= cand_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (state_reg == ST_MUL || state_reg == ST_CHK_MUL) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== rtl/core/srrw_checker.sv =====
// Port-level checks for the selective-repeat receive window, bound to the top.
// Depends on srrw_pkg for the transaction structs, command codes and length bounds.
`timescale 1ns / 1ps
module srrw_port_assertions (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input srrw_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input srrw_pkg::out_t m_data
);
    import srrw_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    a_busy_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd != CMD_NONE |=> !s_ready)
        else $error("input taken again before item finished");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.byte_len != '0 && m_data.byte_len <= LEN_W'(SEG_MAX))
        else $error("segment length out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind selective_repeat_receive_window srrw_port_assertions u_srrw_port_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
